FILE: rtl/utf8gl_pkg.sv
`timescale 1ns / 1ps

package utf8gl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CP_W        = 21;
    localparam int ADV_W       = 8;
    localparam int WIDTH_W     = 16;
    localparam int COUNT_W     = 9;
    // search bounds carry one sign bit so that hi can reach -1
    localparam int BOUND_W     = SLOT_W + 2;

    localparam logic REQ_TEXT = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic                     kind;
        logic [CP_W-1:0]          codepoint;
        logic                     found;
        logic [7:0]               slot;
        logic [ADV_W-1:0]         advance;
        logic signed [WIDTH_W-1:0] width;
    } t_result;

endpackage

FILE: rtl/utf8_glyph_lookup_width.sv
`timescale 1ns / 1ps

// channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------------------
// request   | i_in_valid / o_in_stall   | req_type, text_byte, entry_index/codepoint/advance
// result    | o_out_valid / i_out_stall | result_kind, decoded_codepoint, glyph_*, string_width
// config    | i_cfg_we                  | i_cfg_data (search count)
//
// Load requests and bytes inside a multi-byte sequence are taken in S_IDLE and do not raise o_in_stall.
// A completed codepoint runs its binary search probes in S_CMP (at most 9 for
// 256 entries), one synchronous table read per probe, overlapped with the compare,
// then S_EMIT; an end-of-string byte goes straight to S_EMIT. Synchronous active-low
// reset; the glyph table is not cleared. A stalled result sits in the output register
// while the next request is taken; o_in_stall stays high while a lookup is in flight.

module utf8_glyph_lookup_width
    import utf8gl_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [7:0]                i_text_byte,
    input  logic [SLOT_W-1:0]         i_entry_index,
    input  logic [CP_W-1:0]           i_entry_codepoint,
    input  logic [ADV_W-1:0]          i_entry_advance,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_result_kind,
    output logic [CP_W-1:0]           o_decoded_codepoint,
    output logic                      o_glyph_found,
    output logic [7:0]                o_glyph_slot,
    output logic [ADV_W-1:0]          o_glyph_advance,
    output logic signed [WIDTH_W-1:0] o_string_width,

    input  logic                      i_cfg_we,
    input  logic [COUNT_W-1:0]        i_cfg_data
);

    // glyph table: codepoint and advance side by side
    logic [CP_W+ADV_W-1:0] mem [TABLE_DEPTH];
    logic [CP_W+ADV_W-1:0] r_rd_data;
    logic                  mem_we;
    logic                  mem_re;
    logic [SLOT_W-1:0]     mem_raddr;

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_count;
    logic [CP_W-1:0]       r_partial, n_partial;
    logic [1:0]            r_bytes_rem, n_bytes_rem;
    logic [WIDTH_W-1:0]    r_width_sum, n_width_sum;
    logic [CP_W-1:0]       r_cp, n_cp;
    logic signed [BOUND_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [SLOT_W-1:0]     r_mid, n_mid;
    t_result               r_res, n_res;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  in_accept;
    logic                  out_free;
    logic [COUNT_W-1:0]    eff_count;
    logic [CP_W-1:0]       cont_cp;
    logic [CP_W-1:0]       rd_cp;
    logic [ADV_W-1:0]      rd_adv;
    logic signed [BOUND_W:0] mid_sum;
    logic [WIDTH_W-1:0]    width_add;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign eff_count  = (r_count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : r_count;
    assign cont_cp    = {r_partial[CP_W-7:0], i_text_byte[5:0]};
    assign rd_cp      = r_rd_data[CP_W+ADV_W-1:ADV_W];
    assign rd_adv     = r_rd_data[ADV_W-1:0];
    assign width_add  = r_width_sum + WIDTH_W'(rd_adv);
    assign mem_we     = in_accept && (i_req_type == REQ_LOAD);

    always_comb begin
        n_state     = r_state;
        n_partial   = r_partial;
        n_bytes_rem = r_bytes_rem;
        n_width_sum = r_width_sum;
        n_cp        = r_cp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res       = r_res;
        mem_re      = 1'b0;
        mid_sum     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && i_req_type == REQ_TEXT) begin
                    // a lookup starts when a codepoint completes
                    logic       start;
                    logic [CP_W-1:0] cp;
                    start = 1'b0;
                    cp    = '0;
                    if (r_bytes_rem != 2'd0) begin
                        n_bytes_rem = r_bytes_rem - 2'd1;
                        if (r_bytes_rem == 2'd1) begin
                            start     = 1'b1;
                            cp        = cont_cp;
                            n_partial = '0;
                        end else begin
                            n_partial = cont_cp;
                        end
                    end else if (i_text_byte == 8'h00) begin
                        n_res       = '{kind: KIND_TOTAL, codepoint: '0, found: 1'b0,
                                        slot: '0, advance: '0, width: r_width_sum};
                        n_width_sum = '0;
                        n_state     = S_EMIT;
                    end else if (i_text_byte < 8'h80) begin
                        start = 1'b1;
                        cp    = CP_W'(i_text_byte);
                    end else if ((i_text_byte & 8'hE0) == 8'hC0) begin
                        n_partial   = CP_W'(i_text_byte & 8'h1F);
                        n_bytes_rem = 2'd1;
                    end else if ((i_text_byte & 8'hF0) == 8'hE0) begin
                        n_partial   = CP_W'(i_text_byte & 8'h0F);
                        n_bytes_rem = 2'd2;
                    end else begin
                        n_partial   = CP_W'(i_text_byte & 8'h07);
                        n_bytes_rem = 2'd3;
                    end

                    if (start) begin
                        n_cp  = cp;
                        n_res = '{kind: KIND_GLYPH, codepoint: cp, found: 1'b0,
                                  slot: '0, advance: '0, width: r_width_sum};
                        n_lo  = '0;
                        n_hi  = BOUND_W'(eff_count) - BOUND_W'(1);
                        if (eff_count == '0) begin
                            n_state = S_EMIT;
                        end else begin
                            mid_sum = (BOUND_W+1)'(eff_count) - (BOUND_W+1)'(1);
                            n_mid   = mid_sum[SLOT_W:1];
                            mem_re  = 1'b1;
                            n_state = S_CMP;
                        end
                    end
                end
            end

            S_CMP: begin
                if (rd_cp == r_cp) begin
                    n_width_sum = width_add;
                    n_res.found   = 1'b1;
                    n_res.slot    = 8'(r_mid);
                    n_res.advance = rd_adv;
                    n_res.width   = width_add;
                    n_state       = S_EMIT;
                end else begin
                    if (rd_cp < r_cp) begin
                        n_lo = BOUND_W'(r_mid) + BOUND_W'(1);
                    end else begin
                        n_hi = BOUND_W'(r_mid) - BOUND_W'(1);
                    end
                    if (n_lo <= n_hi) begin
                        // both bounds are non-negative here
                        mid_sum = {n_lo[BOUND_W-1], n_lo} + {n_hi[BOUND_W-1], n_hi};
                        n_mid   = mid_sum[SLOT_W:1];
                        mem_re  = 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign mem_raddr = n_mid;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_entry_index] <= {i_entry_codepoint, i_entry_advance};
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_partial   <= '0;
            r_bytes_rem <= '0;
            r_width_sum <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_partial   <= n_partial;
            r_bytes_rem <= n_bytes_rem;
            r_width_sum <= n_width_sum;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp  <= n_cp;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_res <= n_res;
        if (r_state == S_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_out.kind;
    assign o_decoded_codepoint = r_out.codepoint;
    assign o_glyph_found       = r_out.found;
    assign o_glyph_slot        = r_out.slot;
    assign o_glyph_advance     = r_out.advance;
    assign o_string_width      = r_out.width;

    // the probe in flight lies inside the live search window
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> (r_lo <= BOUND_W'(r_mid)) && (BOUND_W'(r_mid) <= r_hi))
        else $error("search probe outside bounds");

    // an end-of-string byte clears the running width
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req_type == REQ_TEXT && r_bytes_rem == 2'd0 && i_text_byte == 8'h00)
        |=> (r_width_sum == '0) && (r_state == S_EMIT))
        else $error("end of string did not clear width");

    // a new result only appears after the emit state
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result without emit");

    // table writes never overlap a search
    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !mem_re || r_state == S_IDLE)
        else $error("table write during lookup");

endmodule

FILE: tb/tb_utf8_glyph_lookup_width.sv
`timescale 1ns / 1ps

module tb_utf8_glyph_lookup_width;
    import utf8gl_pkg::*;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        text_byte;
        logic [SLOT_W-1:0] entry_index;
        logic [CP_W-1:0]   entry_codepoint;
        logic [ADV_W-1:0]  entry_advance;
    } t_request;

    logic                      i_clk             = 1'b0;
    logic                      i_rst_n           = 1'b0;
    logic                      i_in_valid        = 1'b0;
    logic                      i_req_type        = REQ_TEXT;
    logic [7:0]                i_text_byte       = '0;
    logic [SLOT_W-1:0]         i_entry_index     = '0;
    logic [CP_W-1:0]           i_entry_codepoint = '0;
    logic [ADV_W-1:0]          i_entry_advance   = '0;
    logic                      i_out_stall       = 1'b0;
    logic                      i_cfg_we          = 1'b0;
    logic [COUNT_W-1:0]        i_cfg_data        = '0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic                      o_result_kind;
    logic [CP_W-1:0]           o_decoded_codepoint;
    logic                      o_glyph_found;
    logic [7:0]                o_glyph_slot;
    logic [ADV_W-1:0]          o_glyph_advance;
    logic signed [WIDTH_W-1:0] o_string_width;

    // requests not yet accepted, and lookup/total results still owed by the block
    t_request          request_q[$];
    t_result           owed_results_q[$];

    // table as the block holds it (updated on acceptance) and as the
    // generator has planned it (updated when a load is queued)
    logic [CP_W-1:0]    glyph_cp[TABLE_DEPTH];
    logic [ADV_W-1:0]   glyph_adv[TABLE_DEPTH];
    logic [CP_W-1:0]    planned_cp[TABLE_DEPTH];
    int                 search_count_reg = 0;
    logic [CP_W-1:0]    gathered_cp      = '0;
    int                 bytes_owed       = 0;
    logic [WIDTH_W-1:0] running_width    = '0;

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int error_count    = 0;
    int results_seen   = 0;

    utf8_glyph_lookup_width dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_req_type          (i_req_type),
        .i_text_byte         (i_text_byte),
        .i_entry_index       (i_entry_index),
        .i_entry_codepoint   (i_entry_codepoint),
        .i_entry_advance     (i_entry_advance),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_result_kind       (o_result_kind),
        .o_decoded_codepoint (o_decoded_codepoint),
        .o_glyph_found       (o_glyph_found),
        .o_glyph_slot        (o_glyph_slot),
        .o_glyph_advance     (o_glyph_advance),
        .o_string_width      (o_string_width),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t result %0d mismatch: %s", $time, results_seen, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // decode one accepted request and queue the result it owes, if any
    task automatic predict_request(input t_request r);
        t_result         res;
        logic            complete;
        logic [CP_W-1:0] cp;
        int              lo, hi, mid, searched;
        res      = '0;
        complete = 1'b0;
        cp       = '0;
        if (r.req_type == REQ_LOAD) begin
            glyph_cp[r.entry_index]  = r.entry_codepoint;
            glyph_adv[r.entry_index] = r.entry_advance;
        end else if (bytes_owed != 0) begin
            // continuation: low 6 bits, zero byte is plain data here
            gathered_cp = {gathered_cp[CP_W-7:0], r.text_byte[5:0]};
            bytes_owed--;
            if (bytes_owed == 0) begin
                cp          = gathered_cp;
                gathered_cp = '0;
                complete    = 1'b1;
            end
        end else if (r.text_byte == 8'h00) begin
            res.kind      = KIND_TOTAL;
            res.width     = running_width;
            running_width = '0;
            owed_results_q.push_back(res);
        end else if (r.text_byte < 8'h80) begin
            cp       = CP_W'(r.text_byte);
            complete = 1'b1;
        end else if (r.text_byte[7:5] == 3'b110) begin
            gathered_cp = CP_W'(r.text_byte[4:0]);
            bytes_owed  = 1;
        end else if (r.text_byte[7:4] == 4'b1110) begin
            gathered_cp = CP_W'(r.text_byte[3:0]);
            bytes_owed  = 2;
        end else begin
            gathered_cp = CP_W'(r.text_byte[2:0]);
            bytes_owed  = 3;
        end
        if (complete) begin
            searched      = search_count_reg > TABLE_DEPTH ? TABLE_DEPTH : search_count_reg;
            lo            = 0;
            hi            = searched - 1;
            res.kind      = KIND_GLYPH;
            res.codepoint = cp;
            while (lo <= hi && !res.found) begin
                mid = (lo + hi) / 2;
                if (glyph_cp[mid] == cp) begin
                    res.found   = 1'b1;
                    res.slot    = mid[7:0];
                    res.advance = glyph_adv[mid];
                end else if (glyph_cp[mid] < cp) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            running_width = running_width + WIDTH_W'(res.advance);
            res.width     = running_width;
            owed_results_q.push_back(res);
        end
    endtask

    task automatic push_text(input logic [7:0] value);
        t_request r;
        r.req_type        = REQ_TEXT;
        r.text_byte       = value;
        // unused fields carry junk, the block must ignore them
        r.entry_index     = SLOT_W'($urandom);
        r.entry_codepoint = CP_W'($urandom);
        r.entry_advance   = ADV_W'($urandom);
        request_q.push_back(r);
    endtask

    task automatic push_load(input int slot, input int cp, input int adv);
        t_request r;
        r.req_type        = REQ_LOAD;
        r.text_byte       = 8'($urandom);
        r.entry_index     = slot[SLOT_W-1:0];
        r.entry_codepoint = cp[CP_W-1:0];
        r.entry_advance   = adv[ADV_W-1:0];
        planned_cp[slot]  = cp[CP_W-1:0];
        request_q.push_back(r);
    endtask

    // top two bits are not checked by the decoder, so mess them up now and then
    task automatic push_cont(input logic [5:0] bits6);
        logic [1:0] top;
        top = 2'b10;
        if ($urandom_range(0, 3) == 0) top = 2'($urandom);
        push_text({top, bits6});
    endtask

    // shortest encoding, sometimes overlong; four-byte leads vary in their upper bits
    task automatic push_codepoint(input logic [CP_W-1:0] cp);
        int         len;
        logic [2:0] junk;
        logic [7:0] lead;
        if (cp < 'h80 && cp != 0) len = 1;
        else if (cp < 'h800) len = 2;
        else if (cp < 'h10000) len = 3;
        else len = 4;
        if (len < 4 && $urandom_range(0, 99) < 15) len = $urandom_range(len + 1, 4);
        junk = 3'($urandom);
        case (len)
            1: push_text(cp[7:0]);
            2: begin
                push_text({3'b110, cp[10:6]});
                push_cont(cp[5:0]);
            end
            3: begin
                push_text({4'b1110, cp[15:12]});
                push_cont(cp[11:6]);
                push_cont(cp[5:0]);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: lead = {2'b10, junk, cp[20:18]};
                    1: lead = {5'b11110, cp[20:18]};
                    default: lead = {5'b11111, cp[20:18]};
                endcase
                push_text(lead);
                push_cont(cp[17:12]);
                push_cont(cp[11:6]);
                push_cont(cp[5:0]);
            end
        endcase
    endtask

    task automatic push_random_codepoint();
        case ($urandom_range(1, 4))
            1: push_codepoint(CP_W'($urandom_range(1, 'h7F)));
            2: push_codepoint(CP_W'($urandom_range('h80, 'h7FF)));
            3: push_codepoint(CP_W'($urandom_range('h800, 'hFFFF)));
            default: push_codepoint(CP_W'($urandom_range('h10000, 'h1FFFFF)));
        endcase
    endtask

    // mostly order-keeping table rewrites, a few that break the sort
    task automatic push_random_load();
        int slot, lo_cp, hi_cp, cp;
        slot  = $urandom_range(0, TABLE_DEPTH - 1);
        lo_cp = (slot == 0) ? 0 : int'(planned_cp[slot-1]) + 1;
        hi_cp = (slot == TABLE_DEPTH - 1) ? 'h1FFFFF : int'(planned_cp[slot+1]) - 1;
        if ($urandom_range(0, 4) == 0) cp = $urandom_range(0, 'h1FFFFF);
        else if (lo_cp <= hi_cp) cp = $urandom_range(lo_cp, hi_cp);
        else cp = int'(planned_cp[slot]);
        push_load(slot, cp, $urandom_range(0, 255));
    endtask

    task automatic push_random_text(input int n_items);
        int target, roll;
        target = request_q.size() + n_items;
        while (request_q.size() < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                push_text(8'h00);
            end else if (roll < 8) begin
                push_text(8'($urandom));
            end else if (roll < 11) begin
                // zero where a continuation belongs
                push_text({3'b110, 5'($urandom_range(0, 31))});
                push_text(8'h00);
            end else if (roll < 15) begin
                push_random_load();
            end else if (roll < 70 && search_count_reg != 0) begin
                push_codepoint(planned_cp[$urandom_range(0, search_count_reg - 1)]);
            end else begin
                push_random_codepoint();
            end
        end
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || owed_results_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_search_count(input int n);
        wait_drained();
        // a load or a partial sequence may still be moving through the block
        repeat (16) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n[COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        search_count_reg = n;
    endtask

    always @(posedge i_clk) begin : request_driver
        t_request nxt;
        logic     show;
        if (i_rst_n) begin
            show = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_request(request_q.pop_front());
                show = 1'b0;
            end
            if (!show && request_q.size() != 0) begin
                show = $urandom_range(0, 99) >= send_idle_pct;
            end
            if (show) begin
                nxt = request_q[0];
                i_req_type        <= nxt.req_type;
                i_text_byte       <= nxt.text_byte;
                i_entry_index     <= nxt.entry_index;
                i_entry_codepoint <= nxt.entry_codepoint;
                i_entry_advance   <= nxt.entry_advance;
            end
            i_in_valid <= show;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got, want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_result_kind, o_decoded_codepoint, o_glyph_found, o_glyph_slot,
                       o_glyph_advance, o_string_width};
                if (owed_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d cp %h",
                                              got.kind, got.codepoint));
                end else begin
                    want = owed_results_q.pop_front();
                    check_field("kind", int'(got.kind), int'(want.kind));
                    check_field("codepoint", int'(got.codepoint), int'(want.codepoint));
                    check_field("found", int'(got.found), int'(want.found));
                    check_field("slot", int'(got.slot), int'(want.slot));
                    check_field("advance", int'(got.advance), int'(want.advance));
                    check_field("width", int'(got.width), int'(want.width));
                end
                results_seen++;
            end
            i_out_stall <= $urandom_range(0, 99) < stall_pct;
        end
    end

    initial begin : stimulus
        logic [7:0] opening[22] = '{
            8'h41, 8'h7F,
            8'hC3, 8'hA9,
            8'hE2, 8'h82, 8'hAC,
            8'hF0, 8'h9F, 8'h98, 8'h80,
            8'hFF, 8'hBF, 8'hBF, 8'hBF,
            8'h80, 8'h80, 8'h80, 8'h80,
            8'hC2, 8'h00,
            8'h00
        };
        int phase_count[6];
        int cp;

        phase_count = '{256, 255, 1, 0, 0, 128};
        phase_count[4] = $urandom_range(2, 254);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table after reset: every sequence length and odd leads, all misses
        foreach (opening[k]) push_text(opening[k]);
        wait_drained();

        // sorted table, dense at low codepoints so every encoding length gets hits
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (s < 32) cp = s * 4 + $urandom_range(0, 3);
            else if (s < 64) cp = 128 + (s - 32) * 60 + $urandom_range(0, 59);
            else if (s < 128) cp = 2048 + (s - 64) * 984 + $urandom_range(0, 983);
            else cp = 65536 + (s - 128) * 15872 + $urandom_range(0, 15871);
            push_load(s, cp, $urandom_range(0, 255));
        end
        write_search_count(TABLE_DEPTH);

        push_codepoint(planned_cp[0]);
        push_codepoint(planned_cp[TABLE_DEPTH - 1]);
        push_codepoint(planned_cp[128]);
        push_codepoint(planned_cp[64]);
        push_codepoint(CP_W'(planned_cp[100] + 1));
        push_text(8'h00);

        // long string of wide glyphs: width passes the sign bit and wraps
        push_load(5, int'(planned_cp[5]), 255);
        repeat (270) push_codepoint(planned_cp[5]);
        push_text(8'h00);

        for (int p = 0; p < 6; p++) begin
            write_search_count(phase_count[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            push_random_text(25);
            // sender holds off until the block has returned everything
            wait_drained();
            push_random_text(25);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("utf8_glyph_lookup_width verification clean");
        end else begin
            $display("utf8_glyph_lookup_width verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("utf8_glyph_lookup_width verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/utf8gl_pkg.sv
rtl/utf8_glyph_lookup_width.sv
tb/tb_utf8_glyph_lookup_width.sv
